// ===== hw/rtl/bsld_pkg.sv =====
// Shared constants, types and codes of the button press classifier.
package bsld_pkg;

   // Number of buttons and width of the wrapping tick counter.
   localparam int NUM_BUTTONS = 8;
   localparam int TIME_WIDTH  = 32;

   // Only the first eight buttons have an enable bit, so only they are scanned.
   localparam int MASK_WIDTH  = 8;
   localparam int SCAN_COUNT  = (NUM_BUTTONS < MASK_WIDTH) ? NUM_BUTTONS : MASK_WIDTH;
   localparam int SCAN_W      = (SCAN_COUNT > 1) ? $clog2(SCAN_COUNT) : 1;
   localparam int BTN_W       = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;

   // Field widths of the words on the ports.
   localparam int BUTTON_W    = 3;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;

   // Queue depths.
   localparam int CMDQ_DEPTH  = 2;
   localparam int CMDQ_PTR_W  = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
   localparam int CMDQ_CNT_W  = $clog2(CMDQ_DEPTH + 1);
   localparam int RSPQ_DEPTH  = 4;
   localparam int RSPQ_PTR_W  = (RSPQ_DEPTH > 1) ? $clog2(RSPQ_DEPTH) : 1;
   localparam int RSPQ_CNT_W  = $clog2(RSPQ_DEPTH + 1);

   // Command codes.
   localparam logic CMD_SAMPLE = 1'b0;
   localparam logic CMD_TICK   = 1'b1;

   // Pin levels: the buttons are active low.
   localparam logic LOW  = 1'b0;
   localparam logic HIGH = 1'b1;

   // Register indexes.
   localparam logic [CSR_INDEX_W-1:0] CSR_DEBOUNCE    = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_LONG_PRESS  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_ENABLE_MASK = 2'd2;

   // Register reset values.
   localparam logic [15:0] DEBOUNCE_RESET    = 16'd50;
   localparam logic [15:0] LONG_PRESS_RESET  = 16'd1000;
   localparam logic [MASK_WIDTH-1:0] ENABLE_MASK_RESET = '0;

   // A classified input word waiting for the back end.
   typedef struct packed {
      logic                command;
      logic [BUTTON_W-1:0] button;
      logic                level;
   } cmd_type;

   // One press event.
   typedef struct packed {
      logic [BUTTON_W-1:0] which_button;
      logic                is_long;
      logic                last;
   } evt_type;

endpackage

// ===== hw/rtl/bsld_front.sv =====
// Front end: accepts input words, drops out-of-range samples and queues commands.
module bsld_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_push,
   output logic                          req_full,
   input  logic                          req_command,
   input  logic [bsld_pkg::BUTTON_W-1:0] req_button,
   input  logic                          req_level,
   output logic                          cmd_valid,
   output bsld_pkg::cmd_type             cmd_word,
   input  logic                          cmd_pop
);
   import bsld_pkg::*;

   cmd_type                 queue_ff [CMDQ_DEPTH];
   logic [CMDQ_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [CMDQ_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CMDQ_CNT_W-1:0]   count_ff, count_in;
   logic                    accepted;
   logic                    keep;
   logic                    do_pop;

   assign req_full  = (count_ff == CMDQ_CNT_W'(CMDQ_DEPTH));
   assign accepted  = req_push && !req_full;
   // A sample for a button that does not exist is accepted and discarded.
   assign keep      = (req_command == CMD_TICK) || (int'(req_button) < NUM_BUTTONS);
   assign cmd_valid = (count_ff != '0);
   assign cmd_word  = queue_ff[rd_ptr_ff];
   assign do_pop    = cmd_pop && cmd_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (accepted && keep) begin
         wr_ptr_in = (wr_ptr_ff == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if ((accepted && keep) && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!(accepted && keep) && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accepted && keep) begin
         queue_ff[wr_ptr_ff] <= '{command: req_command, button: req_button, level: req_level};
      end
   end

endmodule

// ===== hw/rtl/bsld_rspq.sv =====
// Result queue holding press events until the consumer takes them.
module bsld_rspq (
   input  logic              clock,
   input  logic              reset,
   input  logic              evt_push,
   input  bsld_pkg::evt_type evt_word,
   output logic              evt_full,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output bsld_pkg::evt_type rsp_word
);
   import bsld_pkg::*;

   evt_type               queue_ff [RSPQ_DEPTH];
   logic [RSPQ_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [RSPQ_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [RSPQ_CNT_W-1:0] count_ff, count_in;
   logic                  do_push;
   logic                  do_pop;

   assign evt_full  = (count_ff == RSPQ_CNT_W'(RSPQ_DEPTH));
   assign rsp_empty = (count_ff == '0);
   assign rsp_word  = queue_ff[rd_ptr_ff];
   assign do_push   = evt_push && !evt_full;
   assign do_pop    = rsp_pop && !rsp_empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == RSPQ_PTR_W'(RSPQ_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == RSPQ_PTR_W'(RSPQ_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!do_push && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         queue_ff[wr_ptr_ff] <= evt_word;
      end
   end

endmodule

// ===== hw/rtl/bsld_back.sv =====
// Back end: button state, tick counter, registers and the scan sequencer.
module bsld_back (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write_enable,
   input  logic [bsld_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [bsld_pkg::CSR_DATA_W-1:0]     csr_write_data,
   input  logic                                cmd_valid,
   input  bsld_pkg::cmd_type                   cmd_word,
   output logic                                cmd_pop,
   output logic                                evt_push,
   output bsld_pkg::evt_type                   evt_word,
   input  logic                                evt_full
);
   import bsld_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_EMIT
   } state_type;

   state_type               state_ff, state_in;
   logic [15:0]             debounce_ff, debounce_in;
   logic [15:0]             long_press_ff, long_press_in;
   logic [MASK_WIDTH-1:0]   enable_ff, enable_in;
   logic [TIME_WIDTH-1:0]   now_ff, now_in;
   logic                    level_ff [NUM_BUTTONS];
   logic                    level_in [NUM_BUTTONS];
   logic                    fired_ff [NUM_BUTTONS];
   logic                    fired_in [NUM_BUTTONS];
   logic [TIME_WIDTH-1:0]   start_ff [NUM_BUTTONS];
   logic [SCAN_W-1:0]       idx_ff, idx_in;
   logic [SCAN_COUNT-1:0]   mask_ff, mask_in;
   logic                    start_we;
   logic [BTN_W-1:0]        sel;
   logic [TIME_WIDTH-1:0]   hold;
   logic [SCAN_W-1:0]       low_idx;
   logic [SCAN_COUNT-1:0]   rest;

   // One button is looked at per cycle: the sampled one when idle, else the scan index.
   assign sel  = (state_ff == ST_IDLE) ? BTN_W'(cmd_word.button) : BTN_W'(idx_ff);
   assign hold = now_ff - start_ff[sel];

   // Lowest pending long press and what remains after it.
   always_comb begin
      low_idx = '0;
      for (int i = SCAN_COUNT - 1; i >= 0; i--) begin
         if (mask_ff[i]) begin
            low_idx = SCAN_W'(i);
         end
      end
   end
   assign rest = mask_ff & (mask_ff - 1'b1);

   always_comb begin
      state_in      = state_ff;
      debounce_in   = debounce_ff;
      long_press_in = long_press_ff;
      enable_in     = enable_ff;
      now_in        = now_ff;
      level_in      = level_ff;
      fired_in      = fired_ff;
      idx_in        = idx_ff;
      mask_in       = mask_ff;
      start_we      = 1'b0;
      cmd_pop       = 1'b0;
      evt_push      = 1'b0;
      evt_word      = '{which_button: cmd_word.button, is_long: 1'b0, last: 1'b1};

      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_DEBOUNCE:    debounce_in   = csr_write_data;
            CSR_LONG_PRESS:  long_press_in = csr_write_data;
            CSR_ENABLE_MASK: enable_in     = csr_write_data[MASK_WIDTH-1:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            // A command is taken only when a result slot is free.
            if (cmd_valid && !evt_full) begin
               cmd_pop = 1'b1;
               if (cmd_word.command == CMD_TICK) begin
                  now_in   = now_ff + 1'b1;
                  idx_in   = '0;
                  mask_in  = '0;
                  state_in = ST_SCAN;
               end else if (cmd_word.level != level_ff[sel]) begin
                  level_in[sel] = cmd_word.level;
                  if (cmd_word.level == LOW) begin
                     start_we      = 1'b1;
                     fired_in[sel] = 1'b0;
                  end else if (hold > TIME_WIDTH'(debounce_ff) && !fired_ff[sel]) begin
                     evt_push = 1'b1;
                  end
               end
            end
         end
         ST_SCAN: begin
            if (level_ff[sel] == LOW && enable_ff[idx_ff] && !fired_ff[sel] &&
                hold >= TIME_WIDTH'(long_press_ff)) begin
               mask_in[idx_ff] = 1'b1;
               fired_in[sel]   = 1'b1;
            end
            if (idx_ff == SCAN_W'(SCAN_COUNT - 1)) begin
               state_in = ST_EMIT;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         ST_EMIT: begin
            if (mask_ff == '0) begin
               state_in = ST_IDLE;
            end else if (!evt_full) begin
               evt_push = 1'b1;
               evt_word = '{which_button: BUTTON_W'(low_idx), is_long: 1'b1,
                            last: (rest == '0)};
               mask_in  = rest;
               if (rest == '0) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         debounce_ff   <= DEBOUNCE_RESET;
         long_press_ff <= LONG_PRESS_RESET;
         enable_ff     <= ENABLE_MASK_RESET;
         now_ff        <= '0;
         idx_ff        <= '0;
         mask_ff       <= '0;
         for (int b = 0; b < NUM_BUTTONS; b++) begin
            level_ff[b] <= HIGH;
            fired_ff[b] <= 1'b0;
         end
      end else begin
         state_ff      <= state_in;
         debounce_ff   <= debounce_in;
         long_press_ff <= long_press_in;
         enable_ff     <= enable_in;
         now_ff        <= now_in;
         idx_ff        <= idx_in;
         mask_ff       <= mask_in;
         level_ff      <= level_in;
         fired_ff      <= fired_in;
      end
   end

   // Press start times are only read while the button is held, so they need no reset.
   always_ff @(posedge clock) begin
      if (start_we) begin
         start_ff[sel] <= now_ff;
      end
   end

endmodule

// ===== hw/rtl/button_short_long_press_detector_unit.sv =====
// Top level of the short and long button press classifier.
//
//   Channel   Direction  Handshake             Word
//   req_      in         push / full           command, button, level
//   rsp_      out        pop / empty           which_button, is_long, last
//   csr_      in         write_enable          index, write_data
//
// The front end takes a word whenever its two-entry command queue has room, so
// input and output never wait on each other directly. On a tick the back end
// advances the counter, steps through the scanned buttons one at a time
// (NUM_BUTTONS, capped at eight) and then emits the long press events one at a
// time, or closes without an event when none fires. The single hold comparator
// is why the buttons are scanned one at a time. Reset is synchronous and leaves
// all buttons released, no marks, the counter at zero and the registers at
// their documented values. A full result queue stalls the back end, which then
// leaves commands in the front queue.
module button_short_long_press_detector_unit (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_push,
   output logic                             req_full,
   input  logic                             req_command,
   input  logic [bsld_pkg::BUTTON_W-1:0]    req_button,
   input  logic                             req_level,
   output logic                             rsp_empty,
   input  logic                             rsp_pop,
   output logic [bsld_pkg::BUTTON_W-1:0]    rsp_which_button,
   output logic                             rsp_is_long,
   output logic                             rsp_last,
   input  logic                             csr_write_enable,
   input  logic [bsld_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [bsld_pkg::CSR_DATA_W-1:0]  csr_write_data
);
   import bsld_pkg::*;

   logic    cmd_valid;
   cmd_type cmd_word;
   logic    cmd_pop;
   logic    evt_push;
   evt_type evt_word;
   logic    evt_full;
   evt_type rsp_word;

   // Front end: accepts words while its queue has room and queues them as commands.
   bsld_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_push    (req_push),
      .req_full    (req_full),
      .req_command (req_command),
      .req_button  (req_button),
      .req_level   (req_level),
      .cmd_valid   (cmd_valid),
      .cmd_word    (cmd_word),
      .cmd_pop     (cmd_pop)
   );

   // Back end: holds the button state and carries out samples and ticks.
   bsld_back u_back (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cmd_valid        (cmd_valid),
      .cmd_word         (cmd_word),
      .cmd_pop          (cmd_pop),
      .evt_push         (evt_push),
      .evt_word         (evt_word),
      .evt_full         (evt_full)
   );

   // Result queue: events wait here until the consumer pops them.
   bsld_rspq u_rspq (
      .clock     (clock),
      .reset     (reset),
      .evt_push  (evt_push),
      .evt_word  (evt_word),
      .evt_full  (evt_full),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_word  (rsp_word)
   );

   assign rsp_which_button = rsp_word.which_button;
   assign rsp_is_long      = rsp_word.is_long;
   assign rsp_last         = rsp_word.last;

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the short and long button press classifier.
`timescale 1ns / 100ps

module testbench;
   import bsld_pkg::*;

   // A tick may emit up to eight events, and up to three commands may be in
   // flight behind the last expected word, so this pause lets the block settle.
   localparam int SETTLE_CYCLES   = 80;
   // Long stretch during which the receiver refuses words, to fill the block.
   localparam int HOLD_OFF_CYCLES = 200;
   // Cycles without any accepted word before the run is given up.
   localparam int WATCHDOG_LIMIT  = 2000;
   // Register index beyond the list, which the block must ignore.
   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED = 2'd3;

   logic                   clock;
   logic                   reset;
   logic                   req_push;
   logic                   req_full;
   logic                   req_command;
   logic [BUTTON_W-1:0]    req_button;
   logic                   req_level;
   logic                   rsp_empty;
   logic                   rsp_pop;
   logic [BUTTON_W-1:0]    rsp_which_button;
   logic                   rsp_is_long;
   logic                   rsp_last;
   logic                   csr_write_enable;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_write_data;

   button_short_long_press_detector_unit u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_command      (req_command),
      .req_button       (req_button),
      .req_level        (req_level),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_which_button (rsp_which_button),
      .rsp_is_long      (rsp_is_long),
      .rsp_last         (rsp_last),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   // Predicted state of the classifier: pin levels, press times, long-press
   // marks, the tick counter and the three registers.
   logic                  pin_level   [NUM_BUTTONS];
   logic [TIME_WIDTH-1:0] press_time  [NUM_BUTTONS];
   logic                  long_marked [NUM_BUTTONS];
   logic [TIME_WIDTH-1:0] tick_count;
   logic [15:0]           debounce_cfg;
   logic [15:0]           long_press_cfg;
   logic [MASK_WIDTH-1:0] enable_mask_cfg;

   // Press events still owed by the block, oldest first.
   evt_type expected_events[$];

   int  mismatch_count;
   int  stall_cycles;
   bit  idling_on;
   bit  hold_request;

   // The clock runs with a 10 ns period.
   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Works out the press events that one accepted word causes, updating the
   // predicted state just as the block should. A level sample only acts on a
   // change of level; a tick advances the counter and scans the buttons in order.
   function automatic void classify_word(input logic cmd, input logic [BUTTON_W-1:0] btn,
                                         input logic lvl);
      evt_type               found[8];
      int                    n;
      int                    b;
      logic [TIME_WIDTH-1:0] hold;
      n = 0;
      if (cmd == CMD_SAMPLE) begin
         if (lvl != pin_level[btn]) begin
            pin_level[btn] = lvl;
            if (lvl == LOW) begin
               press_time[btn]  = tick_count;
               long_marked[btn] = 1'b0;
            end else begin
               // A release counts as a short press only if the hold was strictly
               // longer than the debounce time and no long press fired.
               hold = tick_count - press_time[btn];
               if (hold > debounce_cfg && !long_marked[btn]) begin
                  found[n].which_button = btn;
                  found[n].is_long      = 1'b0;
                  found[n].last         = 1'b0;
                  n++;
               end
            end
         end
      end else begin
         tick_count = tick_count + 1'b1;
         for (b = 0; b < NUM_BUTTONS; b++) begin
            hold = tick_count - press_time[b];
            // Buttons beyond the mask have no enable bit and never fire.
            if (pin_level[b] == LOW && b < MASK_WIDTH && enable_mask_cfg[b]
                && !long_marked[b] && hold >= long_press_cfg) begin
               found[n].which_button = b[BUTTON_W-1:0];
               found[n].is_long      = 1'b1;
               found[n].last         = 1'b0;
               long_marked[b]        = 1'b1;
               n++;
            end
         end
      end
      // The final event of a word carries the last flag.
      for (b = 0; b < n; b++) begin
         if (b == n - 1)
            found[b].last = 1'b1;
         expected_events = {expected_events, found[b]};
      end
   endfunction

   // Offers one word on the input side, with an occasional idle burst first, and
   // predicts its events once the block has taken it. Called at a falling edge;
   // returns at a falling edge with push still high.
   task automatic send_word(input logic cmd, input logic [BUTTON_W-1:0] btn, input logic lvl);
      int gap;
      if (idling_on && $urandom_range(0, 5) == 0) begin
         gap      = $urandom_range(1, 19);
         req_push = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_push    = 1'b1;
      req_command = cmd;
      req_button  = btn;
      req_level   = lvl;
      do
         @(posedge clock);
      while (req_full);
      classify_word(cmd, btn, lvl);
      @(negedge clock);
   endtask

   task automatic send_tick();
      send_word(CMD_TICK, BUTTON_W'($urandom_range(0, 7)), 1'($urandom_range(0, 1)));
   endtask

   // Stops offering words, waits until every owed event has come back, then lets
   // the block finish any command that produces nothing.
   task automatic wait_drained();
      req_push = 1'b0;
      while (expected_events.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Writes one register; only called while the block is idle.
   task automatic write_register(input logic [CSR_INDEX_W-1:0] reg_index,
                                 input logic [CSR_DATA_W-1:0] reg_value);
      csr_write_enable = 1'b1;
      csr_index        = reg_index;
      csr_write_data   = reg_value;
      @(negedge clock);
      csr_write_enable = 1'b0;
      case (reg_index)
         CSR_DEBOUNCE:    debounce_cfg    = reg_value;
         CSR_LONG_PRESS:  long_press_cfg  = reg_value;
         CSR_ENABLE_MASK: enable_mask_cfg = reg_value[MASK_WIDTH-1:0];
         default: ;
      endcase
   endtask

   task automatic write_all(input logic [15:0] debounce, input logic [15:0] long_press,
                            input logic [15:0] mask);
      write_register(CSR_DEBOUNCE, debounce);
      write_register(CSR_LONG_PRESS, long_press);
      write_register(CSR_ENABLE_MASK, mask);
   endtask

   // With the reset values a one-tick hold is far too short for a short press,
   // and no button is enabled for long presses.
   task automatic test_reset_values();
      send_word(CMD_SAMPLE, 3'd4, LOW);
      send_tick();
      send_word(CMD_SAMPLE, 3'd4, HIGH);
      wait_drained();
   endtask

   // A hold of three ticks beats a debounce time of two; a hold of exactly two
   // does not. A repeated level is ignored, and ticks carry arbitrary fields.
   task automatic test_short_press();
      write_all(16'd2, 16'hFFFF, 16'h00FF);
      send_word(CMD_SAMPLE, 3'd0, LOW);
      send_word(CMD_TICK, 3'd7, HIGH);
      send_word(CMD_TICK, 3'd0, LOW);
      send_tick();
      send_word(CMD_SAMPLE, 3'd0, HIGH);
      send_word(CMD_SAMPLE, 3'd7, LOW);
      send_tick();
      send_tick();
      send_word(CMD_SAMPLE, 3'd7, LOW);
      send_word(CMD_SAMPLE, 3'd7, HIGH);
      wait_drained();
   endtask

   // A long-press time of zero fires on the first tick after the press, only for
   // enabled buttons; a marked button gives no short press on release, while an
   // unenabled one does.
   task automatic test_long_press();
      write_all(16'd0, 16'd0, 16'h0082);
      send_word(CMD_SAMPLE, 3'd1, LOW);
      send_word(CMD_SAMPLE, 3'd7, LOW);
      send_word(CMD_SAMPLE, 3'd6, LOW);
      send_tick();
      send_word(CMD_SAMPLE, 3'd1, HIGH);
      send_word(CMD_SAMPLE, 3'd6, HIGH);
      send_word(CMD_SAMPLE, 3'd7, HIGH);
      wait_drained();
   endtask

   // Largest debounce time, a long-press time of one, an empty mask, and a write
   // to an index beyond the register list, which must leave the mask alone.
   task automatic test_register_extremes();
      write_all(16'hFFFF, 16'd1, 16'h0000);
      write_register(CSR_UNUSED, 16'hFFFF);
      send_word(CMD_SAMPLE, 3'd5, LOW);
      send_tick();
      send_tick();
      send_word(CMD_SAMPLE, 3'd5, HIGH);
      wait_drained();
      write_register(CSR_ENABLE_MASK, 16'h00FF);
      send_word(CMD_SAMPLE, 3'd5, LOW);
      send_tick();
      send_word(CMD_SAMPLE, 3'd5, HIGH);
      wait_drained();
   endtask

   // The receiver holds off for a long stretch while every button is pressed and
   // a tick raises eight long presses at once, so the result queue fills and the
   // input side has to stall.
   task automatic test_full_stall();
      int round;
      int b;
      write_all(16'd0, 16'd0, 16'h00FF);
      hold_request = 1'b1;
      for (round = 0; round < 2; round++) begin
         for (b = 0; b < NUM_BUTTONS; b++)
            send_word(CMD_SAMPLE, b[BUTTON_W-1:0], LOW);
         send_tick();
         for (b = 0; b < NUM_BUTTONS; b++)
            send_word(CMD_SAMPLE, b[BUTTON_W-1:0], HIGH);
      end
      wait_drained();
   endtask

   // Random words: mostly level changes and ticks, which form press, hold and
   // release sequences, with some repeated levels as noise.
   task automatic random_words(input int count);
      int                  i;
      int                  pick;
      logic [BUTTON_W-1:0] btn;
      for (i = 0; i < count; i++) begin
         pick = $urandom_range(0, 99);
         btn  = BUTTON_W'($urandom_range(0, 7));
         if (pick < 40)
            send_tick();
         else if (pick < 90)
            send_word(CMD_SAMPLE, btn, !pin_level[btn]);
         else
            send_word(CMD_SAMPLE, btn, 1'($urandom_range(0, 1)));
      end
      wait_drained();
   endtask

   // Four phases with different register settings. Idling is on in the first
   // and third, off in the second and in the closing phase.
   task automatic test_random_traffic();
      write_all(16'($urandom_range(0, 3)), 16'($urandom_range(1, 6)),
                16'($urandom_range(0, 16'hFFFF)));
      random_words(55);
      idling_on = 1'b0;
      write_all(16'd0, 16'd0, 16'h00FF);
      random_words(55);
      idling_on = 1'b1;
      write_all(16'($urandom_range(0, 5)), 16'($urandom_range(0, 10)),
                16'($urandom_range(0, 255)));
      random_words(55);
      idling_on = 1'b0;
      write_all(16'($urandom_range(0, 4)), 16'($urandom_range(0, 8)),
                16'($urandom_range(0, 255)));
      random_words(55);
   endtask

   // Receiver: takes words whenever it can, apart from random stall bursts and
   // the one long hold-off requested by the stall test.
   initial begin
      rsp_pop = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_pop      = 1'b0;
            repeat (HOLD_OFF_CYCLES) @(negedge clock);
         end else if (idling_on && $urandom_range(0, 7) == 0) begin
            rsp_pop = 1'b0;
            repeat ($urandom_range(0, 18)) @(negedge clock);
         end else begin
            rsp_pop = 1'b1;
         end
      end
   end

   // Checks every accepted result word against the oldest owed event.
   always @(posedge clock) begin
      evt_type want;
      if (!reset && rsp_pop && !rsp_empty) begin
         if (expected_events.size() == 0) begin
            if (mismatch_count < 10)
               $display("%0t: unexpected event button %0d long %0b last %0b", $realtime,
                        rsp_which_button, rsp_is_long, rsp_last);
            mismatch_count++;
         end else begin
            want = expected_events.pop_front();
            if (rsp_which_button !== want.which_button || rsp_is_long !== want.is_long
                || rsp_last !== want.last) begin
               if (mismatch_count < 10)
                  $display("%0t: expected button %0d long %0b last %0b, got %0d %0b %0b",
                           $realtime, want.which_button, want.is_long, want.last,
                           rsp_which_button, rsp_is_long, rsp_last);
               mismatch_count++;
            end
         end
      end
   end

   // Watchdog: gives up when no word has moved on either side for too long.
   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty))
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // Main sequence: reset, predictor set to its reset state, then the tests.
   initial begin
      int b;
      reset            = 1'b1;
      req_push         = 1'b0;
      req_command      = CMD_SAMPLE;
      req_button       = '0;
      req_level        = HIGH;
      csr_write_enable = 1'b0;
      csr_index        = CSR_DEBOUNCE;
      csr_write_data   = '0;
      mismatch_count   = 0;
      stall_cycles     = 0;
      idling_on        = 1'b1;
      hold_request     = 1'b0;
      for (b = 0; b < NUM_BUTTONS; b++) begin
         pin_level[b]   = HIGH;
         press_time[b]  = '0;
         long_marked[b] = 1'b0;
      end
      tick_count      = '0;
      debounce_cfg    = DEBOUNCE_RESET;
      long_press_cfg  = LONG_PRESS_RESET;
      enable_mask_cfg = ENABLE_MASK_RESET;

      repeat (10) @(negedge clock);
      reset = 1'b0;

      test_reset_values();
      test_short_press();
      test_long_press();
      test_register_extremes();
      test_full_stall();
      test_random_traffic();

      if (mismatch_count == 0 && expected_events.size() == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
